// ----- design/multiturn_encoder_tracker_macros.svh -----
// ----------------------------------------------------------------------------
// Multi-turn encoder tracker assertion macros
// Shared helpers for concurrent assertions on the tracker ports.
// ----------------------------------------------------------------------------
`ifndef MULTITURN_ENCODER_TRACKER_MACROS_SVH
`define MULTITURN_ENCODER_TRACKER_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define MTT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define MTT_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/mtt_pkg.sv -----
// ----------------------------------------------------------------------------
// Multi-turn encoder tracker package
// Field widths, packing offsets and arithmetic constants.
// ----------------------------------------------------------------------------
package mtt_pkg;

	localparam int ANGLE_W = 13;
	localparam int SPEED_W = 16;
	localparam int CUR_W   = 16;
	localparam int TEMP_W  = 8;
	localparam int REL_W   = 14;
	localparam int TURN_W  = 16;
	localparam int POS_W   = 29;
	localparam int FSPD_W  = 10;

	localparam int IN_W  = 64;
	localparam int OUT_W = 104;

	// Half a turn and the turn-count limit.
	localparam logic signed [REL_W-1:0]  HALF_TURN  = 14'sd4096;
	localparam logic signed [TURN_W-1:0] TURN_LIMIT = 16'sd32000;

	// Adding this to a 14-bit value moves it by a full turn, in either direction.
	localparam logic [REL_W-1:0] FULL_TURN = 14'h2000;

	// x/100 for |x| <= 32768 as (|x| * 5243) >> 19, exact after truncation.
	localparam logic [12:0] DIV100_RECIP = 13'd5243;
	localparam int          DIV100_SHIFT = 19;

	// x/5 for |x| <= 2047 as (|x| * 13108) >> 16, exact after truncation.
	localparam logic [13:0] DIV5_RECIP = 14'd13108;
	localparam int          DIV5_SHIFT = 16;

endpackage

// ----- design/mtt_div100.sv -----
// ----------------------------------------------------------------------------
// Signed divide by 100
// Truncates toward zero using a reciprocal multiply on the magnitude.
// ----------------------------------------------------------------------------
module mtt_div100 (
	input  logic signed [mtt_pkg::SPEED_W-1:0] dividend,
	output logic signed [mtt_pkg::FSPD_W-1:0]  quotient
);
	import mtt_pkg::*;

	logic [SPEED_W-1:0]    mag;
	logic [SPEED_W+12:0]   prod;
	logic [FSPD_W-1:0]     q;

	always_comb begin
		mag  = dividend[SPEED_W-1] ? (SPEED_W'(0) - dividend) : dividend;
		prod = mag * DIV100_RECIP;
		q    = prod[DIV100_SHIFT +: FSPD_W];
		quotient = dividend[SPEED_W-1] ? signed'(FSPD_W'(0) - q) : signed'(q);
	end

endmodule

// ----- design/multiturn_encoder_tracker.sv -----
// ----------------------------------------------------------------------------
// Multi-turn encoder tracker
// Unwraps a 13-bit single-turn encoder into a turn count and a continuous
// position, reports the angle relative to a home angle and smooths speed.
// ----------------------------------------------------------------------------
//
//   Channel | Signals                            | Content
//   --------+------------------------------------+----------------------------
//   input   | s_tvalid s_tready s_tdata          | one motor feedback frame
//   output  | m_tvalid m_tready m_tdata          | one tracked result per item
//   config  | cfg_valid cfg_ready cfg_data       | home angle, 13 bits, ready
//
// Each item is captured in the input register and then moves into the
// result register, which drives the output; a stall on m_tready can hold
// it in the input register. One item is accepted every cycle when the
// output is not stalled.
// The turn count, previous angle and previous filtered speed are updated as
// an item moves into the result register, so the next item sees them at once.
// Reset clears the turn count, the previous angle and speed, the home angle
// and both valid flags. A stall on m_tready holds the result; the input
// register keeps accepting until it is full as well.
// ----------------------------------------------------------------------------
module multiturn_encoder_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// angle_raw, speed_raw, current_raw, coil_temp, driver_temp, zero pad
	input  logic [mtt_pkg::IN_W-1:0]      s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// relative_angle, turn_count, continuous_position, filtered_speed,
	// turn_reset, current_out, coil_temp_out, driver_temp_out, zero pad
	output logic [mtt_pkg::OUT_W-1:0]     m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mtt_pkg::ANGLE_W-1:0]   cfg_data
);
	import mtt_pkg::*;

	// Input fields.
	logic [ANGLE_W-1:0]        in_angle;
	logic signed [SPEED_W-1:0] in_speed;
	logic signed [FSPD_W-1:0]  in_nspd;

	// Input register. Speed is stored already divided by 100.
	logic                      valid_s1;
	logic [ANGLE_W-1:0]        angle_s1;
	logic signed [FSPD_W-1:0]  nspd_s1;
	logic [CUR_W-1:0]          cur_s1;
	logic [TEMP_W-1:0]         coil_s1;
	logic [TEMP_W-1:0]         drv_s1;

	// Result register.
	logic                      valid_s2;
	logic [REL_W-1:0]          rel_s2;
	logic [TURN_W-1:0]         turns_s2;
	logic [POS_W-1:0]          pos_s2;
	logic [FSPD_W-1:0]         filt_s2;
	logic                      flag_s2;
	logic [CUR_W-1:0]          cur_s2;
	logic [TEMP_W-1:0]         coil_s2;
	logic [TEMP_W-1:0]         drv_s2;

	// Tracking state and configuration.
	logic [ANGLE_W-1:0]        home_q;
	logic [ANGLE_W-1:0]        prev_angle_q;
	logic signed [TURN_W-1:0]  turns_q;
	logic signed [FSPD_W-1:0]  prev_speed_q;

	// Step logic.
	logic                      load_s2;
	logic                      adv_s1;
	logic signed [REL_W-1:0]   err;
	logic [REL_W-1:0]          rel;
	logic signed [REL_W-1:0]   jump;
	logic signed [TURN_W-1:0]  turns_step;
	logic                      runaway;
	logic signed [TURN_W-1:0]  turns_nxt;
	logic signed [11:0]        spd_sum;
	logic [11:0]               spd_abs;
	logic [24:0]               spd_prod;
	logic [FSPD_W-1:0]         spd_q;
	logic signed [FSPD_W-1:0]  filt;

	assign in_angle = s_tdata[ANGLE_W-1:0];
	assign in_speed = signed'(s_tdata[ANGLE_W +: SPEED_W]);

	// The divide by 100 sits ahead of the input register so the filter stage
	// carries only the divide by 5.
	mtt_div100 u_div100 (
		.dividend (in_speed),
		.quotient (in_nspd)
	);

	// The result register loads whenever it is empty or being drained; the
	// input register moves on whenever the result register loads.
	assign load_s2   = !valid_s2 || m_tready;
	assign adv_s1    = valid_s1 && load_s2;
	assign s_tready  = !valid_s1 || load_s2;
	assign cfg_ready = 1'b1;

	function automatic logic [11:0] in_nspd_ext(input logic [FSPD_W-1:0] v);
		in_nspd_ext = {{(12-FSPD_W){v[FSPD_W-1]}}, v};
	endfunction

	always_comb begin
		// Angle relative to home, folded to within half a turn.
		err = signed'({1'b0, angle_s1} - {1'b0, home_q});
		if (err > HALF_TURN || err < -HALF_TURN) begin
			rel = err + FULL_TURN;
		end else begin
			rel = err;
		end

		// A jump of more than half a turn between frames is a wrap.
		jump = signed'({1'b0, angle_s1} - {1'b0, prev_angle_q});
		if (jump < -HALF_TURN) begin
			turns_step = turns_q + 16'sd1;
		end else if (jump > HALF_TURN) begin
			turns_step = turns_q - 16'sd1;
		end else begin
			turns_step = turns_q;
		end
		runaway   = (turns_step > TURN_LIMIT) || (turns_step < -TURN_LIMIT);
		turns_nxt = runaway ? '0 : turns_step;

		// Filtered speed: (4 * previous + new) / 5, truncated toward zero.
		spd_sum  = signed'({prev_speed_q, 2'b00}) + 12'(in_nspd_ext(nspd_s1));
		spd_abs  = spd_sum[11] ? (12'(0) - spd_sum) : spd_sum;
		spd_prod = spd_abs[10:0] * DIV5_RECIP;
		spd_q    = {1'b0, spd_prod[DIV5_SHIFT +: FSPD_W-1]};
		filt     = spd_sum[11] ? signed'(FSPD_W'(0) - spd_q) : signed'(spd_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			home_q       <= '0;
			prev_angle_q <= '0;
			turns_q      <= '0;
			prev_speed_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				home_q <= cfg_data;
			end
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				prev_angle_q <= angle_s1;
				turns_q      <= turns_nxt;
				prev_speed_q <= filt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			angle_s1 <= in_angle;
			nspd_s1  <= in_nspd;
			cur_s1   <= s_tdata[ANGLE_W+SPEED_W +: CUR_W];
			coil_s1  <= s_tdata[ANGLE_W+SPEED_W+CUR_W +: TEMP_W];
			drv_s1   <= s_tdata[ANGLE_W+SPEED_W+CUR_W+TEMP_W +: TEMP_W];
		end
		if (adv_s1) begin
			rel_s2   <= rel;
			turns_s2 <= turns_nxt;
			// The angle is below one turn, so the position is a concatenation.
			pos_s2   <= {turns_nxt, angle_s1};
			filt_s2  <= filt;
			flag_s2  <= runaway;
			cur_s2   <= cur_s1;
			coil_s2  <= coil_s1;
			drv_s2   <= drv_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, drv_s2, coil_s2, cur_s2, flag_s2, filt_s2,
		pos_s2, turns_s2, rel_s2};

endmodule

// ----- design/mtt_checker.sv -----
// ----------------------------------------------------------------------------
// Multi-turn encoder tracker checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "multiturn_encoder_tracker_macros.svh"

module mtt_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_tvalid,
	input logic [mtt_pkg::OUT_W-1:0] m_tdata
);
	import mtt_pkg::*;

	logic signed [TURN_W-1:0] turns_seen;
	logic signed [TURN_W-1:0] pos_turns;
	logic                     reset_seen;
	logic                     turns_legal;

	assign turns_seen  = signed'(m_tdata[29:14]);
	assign pos_turns   = signed'(m_tdata[58:43]);
	assign reset_seen  = m_tdata[69];
	assign turns_legal = (turns_seen <= TURN_LIMIT) && (turns_seen >= -TURN_LIMIT);

	// The turn count never leaves the limit.
	`MTT_ASSERT(a_turn_range, m_tvalid |-> turns_legal, "turn count out of range")

	// The upper position bits are the reported turn count.
	`MTT_ASSERT(a_pos_turns, m_tvalid |-> (pos_turns == turns_seen), "position and count disagree")

	// A runaway result always carries a zero turn count.
	`MTT_ASSERT(a_reset_zero, (m_tvalid && reset_seen) |-> (turns_seen == '0), "runaway not cleared")

	// A reset edge leaves no result showing.
	`MTT_ASSERT_ALWAYS(a_rst_idle, !arst_n |=> !m_tvalid, "result valid after reset")

endmodule

bind multiturn_encoder_tracker mtt_checker u_mtt_checker (.*);
